// ===== hw/rtl/kche_pkg.sv =====
// shared types, constants and sizes of the key click/hold event detector
package kche_pkg;

  // number of keys tracked and the width of a key address
  localparam int NUM_KEYS = 16;
  localparam int KEY_W    = 4;
  localparam int ADDR_W   = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  // events one sample can raise at most
  localparam int MAX_EV = 3;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POLL_PERIOD     = 3'd0,
    REG_CLICK_THRESHOLD = 3'd1,
    REG_HOLD_THRESHOLD  = 3'd2,
    REG_REPEAT_PERIOD   = 3'd3,
    REG_GAP_THRESHOLD   = 3'd4
  } reg_idx_t;

  // reset values of the configuration registers
  localparam logic [7:0]  POLL_PERIOD_RST     = 8'd1;
  localparam logic [15:0] CLICK_THRESHOLD_RST = 16'd20;
  localparam logic [15:0] HOLD_THRESHOLD_RST  = 16'd1000;
  localparam logic [15:0] REPEAT_PERIOD_RST   = 16'd200;
  localparam logic [15:0] GAP_THRESHOLD_RST   = 16'd200;

  // per-key mode
  typedef enum logic [2:0] {
    MODE_RELEASED    = 3'd0,
    MODE_PRE_PRESS   = 3'd1,
    MODE_PRE_LONG    = 3'd2,
    MODE_LONG_HOLD   = 3'd3,
    MODE_MULTI_CLICK = 3'd4
  } mode_t;

  // event codes
  typedef enum logic [2:0] {
    EV_PRESS       = 3'd0,
    EV_FIRST_LONG  = 3'd1,
    EV_HOLD_REPEAT = 3'd2,
    EV_LONG_END    = 3'd3,
    EV_MULTI_CLICK = 3'd4,
    EV_RELEASE     = 3'd5
  } ev_code_t;

  // one key's stored entry; all zero is the reset state
  typedef struct packed {
    mode_t       mode;
    logic [15:0] press;
    logic [15:0] gap;
    logic [15:0] rep;
    logic [7:0]  clicks;
    logic [15:0] held;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // configuration as seen by the update logic
  typedef struct packed {
    logic [7:0]  poll_period;
    logic [15:0] click_threshold;
    logic [15:0] hold_threshold;
    logic [15:0] repeat_period;
    logic [15:0] gap_threshold;
  } cfg_t;

  // events raised by one sample
  typedef struct packed {
    logic [1:0]              num;
    logic [MAX_EV-1:0][2:0]  codes;
    logic [7:0]              clicks;
    logic [15:0]             held;
  } ev_list_t;

endpackage

// ===== hw/rtl/kche_ram.sv =====
// generic single-write, single-read ram with registered read data
module kche_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port, read port returns the old contents on a collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/kche_step.sv =====
// next-state and event logic for one sample of one key
module kche_step (
  input  kche_pkg::entry_t   cur,
  input  logic               pressed,
  input  kche_pkg::cfg_t     cfg,
  output kche_pkg::entry_t   nxt,
  output kche_pkg::ev_list_t ev
);

  logic [16:0] press_sum;
  logic [16:0] gap_sum;
  logic [15:0] press_inc;
  logic [15:0] gap_inc;
  logic [15:0] poll_ext;

  // saturating timer advances
  assign poll_ext  = {8'd0, cfg.poll_period};
  assign press_sum = {1'b0, cur.press} + {1'b0, poll_ext};
  assign gap_sum   = {1'b0, cur.gap} + {1'b0, poll_ext};
  assign press_inc = press_sum[16] ? 16'hFFFF : press_sum[15:0];
  assign gap_inc   = gap_sum[16] ? 16'hFFFF : gap_sum[15:0];

  // per-key state machine
  always_comb begin
    nxt = cur;
    ev  = '0;

    nxt.press = pressed ? press_inc : 16'd0;
    if (!pressed && (cur.mode == kche_pkg::MODE_LONG_HOLD)) begin
      nxt.held = cur.press;
    end
    nxt.gap = (cur.mode == kche_pkg::MODE_MULTI_CLICK) ? gap_inc : 16'd0;
    ev.held   = nxt.held;
    ev.clicks = cur.clicks;

    unique case (cur.mode)
      kche_pkg::MODE_RELEASED: begin
        nxt.clicks = 8'd0;
        if (pressed) begin
          nxt.mode = kche_pkg::MODE_PRE_PRESS;
        end
      end
      kche_pkg::MODE_PRE_PRESS: begin
        if (!pressed) begin
          nxt.mode = kche_pkg::MODE_RELEASED;
        end else if (nxt.press > cfg.click_threshold) begin
          nxt.mode     = kche_pkg::MODE_PRE_LONG;
          ev.codes[0]  = kche_pkg::EV_PRESS;
          ev.num       = 2'd1;
        end
      end
      kche_pkg::MODE_PRE_LONG: begin
        if (!pressed) begin
          nxt.mode = kche_pkg::MODE_MULTI_CLICK;
          if (cur.clicks != 8'hFF) begin
            nxt.clicks = cur.clicks + 8'd1;
          end
        end else if (nxt.press > cfg.hold_threshold) begin
          nxt.mode    = kche_pkg::MODE_LONG_HOLD;
          nxt.rep     = cfg.repeat_period;
          ev.codes[0] = kche_pkg::EV_FIRST_LONG;
          ev.num      = 2'd1;
        end
      end
      kche_pkg::MODE_LONG_HOLD: begin
        // repeat timer counts down to zero, reload and fire on zero
        if (cur.rep != 16'd0) begin
          nxt.rep = (cur.rep > poll_ext) ? (cur.rep - poll_ext) : 16'd0;
        end else begin
          nxt.rep     = cfg.repeat_period;
          ev.codes[0] = kche_pkg::EV_HOLD_REPEAT;
          ev.num      = 2'd1;
        end
        if (!pressed) begin
          nxt.mode = kche_pkg::MODE_RELEASED;
          if (cur.rep != 16'd0) begin
            ev.codes[0] = kche_pkg::EV_LONG_END;
            ev.codes[1] = kche_pkg::EV_RELEASE;
            ev.num      = 2'd2;
          end else begin
            ev.codes[1] = kche_pkg::EV_LONG_END;
            ev.codes[2] = kche_pkg::EV_RELEASE;
            ev.num      = 2'd3;
          end
        end
      end
      kche_pkg::MODE_MULTI_CLICK: begin
        if (nxt.gap > cfg.gap_threshold) begin
          nxt.mode    = kche_pkg::MODE_RELEASED;
          ev.codes[0] = kche_pkg::EV_MULTI_CLICK;
          ev.codes[1] = kche_pkg::EV_RELEASE;
          ev.num      = 2'd2;
        end else if (nxt.press > cfg.click_threshold) begin
          nxt.mode = kche_pkg::MODE_PRE_LONG;
        end
      end
      default: begin
        nxt.mode = kche_pkg::MODE_RELEASED;
      end
    endcase
  end

endmodule

// ===== hw/rtl/key_click_hold_event_fsm.sv =====
// top level of the key click/hold event detector: key state ram, update and event queue
//
//  channel | signals                                             | direction
//  --------+-----------------------------------------------------+----------
//  sample  | in_valid, in_stall, key_index, pressed              | in
//  event   | out_valid, out_stall, event_key, event_code,        | out
//          | click_count, hold_time, last                        |
//  config  | wr_en, wr_index, wr_data                            | in
//
// a sample is read from the key ram in the cycle it is accepted and written back as it
// advances; a same-key sample right behind takes the written entry by forwarding. with
// out_stall low, samples of at most one event each go in, and events go out, one per
// cycle; a sample raising n events holds the queue till the last is taken. reset clears
// per-key valid bits at once, no clearing pass; an invalid key reads as released with
// zero timers. out_stall backs up into in_stall through the event queue.
module key_click_hold_event_fsm (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [kche_pkg::KEY_W-1:0]     key_index,
  input  logic                           pressed,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [kche_pkg::KEY_W-1:0]     event_key,
  output logic [2:0]                     event_code,
  output logic [7:0]                     click_count,
  output logic [15:0]                    hold_time,
  output logic                           last,
  input  logic                           wr_en,
  input  logic [kche_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [kche_pkg::CFG_DATA_W-1:0] wr_data
);

  kche_pkg::cfg_t cfg;

  logic                                in_acc;
  logic                                key_ok;
  logic [kche_pkg::ADDR_W-1:0]         in_addr;
  logic [kche_pkg::NUM_KEYS-1:0]       ent_valid;

  logic                                s1_valid;
  logic [kche_pkg::ADDR_W-1:0]         s1_addr;
  logic [kche_pkg::KEY_W-1:0]          s1_key;
  logic                                s1_pressed;
  logic                                s1_vbit;
  logic                                s1_fwd;
  kche_pkg::entry_t                    s1_fwd_data;
  logic [kche_pkg::ENTRY_W-1:0]        ram_rdata;
  kche_pkg::entry_t                    cur;
  kche_pkg::entry_t                    nxt;
  kche_pkg::ev_list_t                  ev;
  logic                                s1_adv;

  logic [1:0]                          s2_cnt;
  logic [1:0]                          s2_idx;
  logic [kche_pkg::KEY_W-1:0]          s2_key;
  logic [kche_pkg::MAX_EV-1:0][2:0]    s2_codes;
  logic [7:0]                          s2_clicks;
  logic [15:0]                         s2_held;
  logic                                out_acc;
  logic                                s2_done;
  logic                                s2_free;

  function automatic logic [kche_pkg::ADDR_W-1:0] in_addr_of(
    input logic [kche_pkg::KEY_W-1:0] k
  );
    return k[kche_pkg::ADDR_W-1:0];
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.poll_period     <= kche_pkg::POLL_PERIOD_RST;
      cfg.click_threshold <= kche_pkg::CLICK_THRESHOLD_RST;
      cfg.hold_threshold  <= kche_pkg::HOLD_THRESHOLD_RST;
      cfg.repeat_period   <= kche_pkg::REPEAT_PERIOD_RST;
      cfg.gap_threshold   <= kche_pkg::GAP_THRESHOLD_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        kche_pkg::REG_POLL_PERIOD:     cfg.poll_period     <= wr_data[7:0];
        kche_pkg::REG_CLICK_THRESHOLD: cfg.click_threshold <= wr_data;
        kche_pkg::REG_HOLD_THRESHOLD:  cfg.hold_threshold  <= wr_data;
        kche_pkg::REG_REPEAT_PERIOD:   cfg.repeat_period   <= wr_data;
        kche_pkg::REG_GAP_THRESHOLD:   cfg.gap_threshold   <= wr_data;
        default: begin
        end
      endcase
    end
  end

  // request handshakes and pipeline advance
  assign in_addr  = in_addr_of(key_index);
  assign key_ok   = {1'b0, key_index} < (kche_pkg::KEY_W + 1)'(kche_pkg::NUM_KEYS);
  assign out_valid = (s2_cnt != 2'd0);
  assign out_acc  = out_valid && !out_stall;
  assign last     = (s2_idx == (s2_cnt - 2'd1));
  assign s2_done  = out_acc && last;
  assign s2_free  = (s2_cnt == 2'd0) || s2_done;
  assign s1_adv   = s1_valid && ((ev.num == 2'd0) || s2_free);
  assign in_stall = s1_valid && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  // key state ram
  kche_ram #(
    .WIDTH (kche_pkg::ENTRY_W),
    .DEPTH (kche_pkg::NUM_KEYS)
  ) u_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_addr),
    .wdata (nxt),
    .re    (in_acc),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  // per-key written flags
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= '0;
    end else if (s1_adv) begin
      ent_valid[s1_addr] <= 1'b1;
    end
  end

  // read stage: capture the sample, its written flag and a forward of a same-key write
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= key_ok;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_addr     <= in_addr;
      s1_key      <= key_index;
      s1_pressed  <= pressed;
      s1_vbit     <= ent_valid[in_addr];
      s1_fwd      <= s1_adv && (s1_addr == in_addr);
      s1_fwd_data <= nxt;
    end
  end

  // entry as it stands before this sample
  always_comb begin
    if (s1_fwd) begin
      cur = s1_fwd_data;
    end else if (s1_vbit) begin
      cur = kche_pkg::entry_t'(ram_rdata);
    end else begin
      cur = kche_pkg::entry_t'('0);
    end
  end

  kche_step u_step (
    .cur     (cur),
    .pressed (s1_pressed),
    .cfg     (cfg),
    .nxt     (nxt),
    .ev      (ev)
  );

  // event queue: holds one sample's events, drains one per cycle while out_stall is low
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_cnt <= 2'd0;
      s2_idx <= 2'd0;
    end else if (s1_adv && (ev.num != 2'd0)) begin
      s2_cnt <= ev.num;
      s2_idx <= 2'd0;
    end else if (s2_done) begin
      s2_cnt <= 2'd0;
      s2_idx <= 2'd0;
    end else if (out_acc) begin
      s2_idx <= s2_idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && (ev.num != 2'd0)) begin
      s2_key    <= s1_key;
      s2_codes  <= ev.codes;
      s2_clicks <= ev.clicks;
      s2_held   <= ev.held;
    end
  end

  // event fields
  assign event_key   = s2_key;
  assign event_code  = s2_codes[s2_idx];
  assign click_count = (event_code == kche_pkg::EV_MULTI_CLICK) ? s2_clicks : 8'd0;
  assign hold_time   = (event_code == kche_pkg::EV_LONG_END) ? s2_held : 16'd0;

endmodule

// ===== tb/tb_top.sv =====
// testbench of the key click/hold event detector: stimulus, event prediction and checks
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD = 8;
  localparam int RESET_CYCLES = 8;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CAP = 5000;
  localparam int RX_HOLD_CYCLES = 200;
  localparam int RANDOM_QUOTA = 230;
  localparam int WATCHDOG_CYCLES = 250000;
  localparam int MAX_RUN = 12;
  localparam logic [kche_pkg::CFG_IDX_W-1:0] FIRST_UNMAPPED_IDX = 3'd5;

  // one event as the port reports it
  typedef struct packed {
    logic [kche_pkg::KEY_W-1:0] key;
    kche_pkg::ev_code_t         code;
    logic [7:0]                 cnt;
    logic [15:0]                hold;
    logic                       last;
  } key_event_t;

  // per-key timers and modes, configuration copy and the events still owed
  class key_event_tracker;
    kche_pkg::mode_t mode        [kche_pkg::NUM_KEYS];
    logic [15:0]     press_time  [kche_pkg::NUM_KEYS];
    logic [15:0]     gap_time    [kche_pkg::NUM_KEYS];
    logic [15:0]     repeat_left [kche_pkg::NUM_KEYS];
    logic [7:0]      click_cnt   [kche_pkg::NUM_KEYS];
    logic [15:0]     hold_len    [kche_pkg::NUM_KEYS];
    kche_pkg::cfg_t  cfg;
    key_event_t      awaited [$];
    int              errors;
    int              checked;

    function new();
      foreach (mode[i]) begin
        mode[i]        = kche_pkg::MODE_RELEASED;
        press_time[i]  = '0;
        gap_time[i]    = '0;
        repeat_left[i] = '0;
        click_cnt[i]   = '0;
        hold_len[i]    = '0;
      end
      cfg.poll_period     = kche_pkg::POLL_PERIOD_RST;
      cfg.click_threshold = kche_pkg::CLICK_THRESHOLD_RST;
      cfg.hold_threshold  = kche_pkg::HOLD_THRESHOLD_RST;
      cfg.repeat_period   = kche_pkg::REPEAT_PERIOD_RST;
      cfg.gap_threshold   = kche_pkg::GAP_THRESHOLD_RST;
      errors  = 0;
      checked = 0;
    endfunction

    function void set_reg(logic [kche_pkg::CFG_IDX_W-1:0] idx,
                          logic [kche_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        kche_pkg::REG_POLL_PERIOD:     cfg.poll_period     = data[7:0];
        kche_pkg::REG_CLICK_THRESHOLD: cfg.click_threshold = data;
        kche_pkg::REG_HOLD_THRESHOLD:  cfg.hold_threshold  = data;
        kche_pkg::REG_REPEAT_PERIOD:   cfg.repeat_period   = data;
        kche_pkg::REG_GAP_THRESHOLD:   cfg.gap_threshold   = data;
        default: ;
      endcase
    endfunction

    // timer advance by one poll period, saturating
    function logic [15:0] bump(logic [15:0] t);
      logic [16:0] s;
      s = {1'b0, t} + {9'd0, cfg.poll_period};
      return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    function void push_event(logic [kche_pkg::KEY_W-1:0] k, kche_pkg::ev_code_t c,
                             logic [7:0] cnt, logic [15:0] hold);
      key_event_t e;
      e.key  = k;
      e.code = c;
      e.cnt  = cnt;
      e.hold = hold;
      e.last = 1'b0;
      awaited.push_back(e);
    endfunction

    // one accepted sample: update the key and queue the events it raises
    function void note_sample(logic [kche_pkg::KEY_W-1:0] k, logic p);
      int before_cnt;
      before_cnt = awaited.size();
      if (k >= kche_pkg::NUM_KEYS) return;

      // press timer, and hold length captured on release from a long hold
      if (!p) begin
        if (mode[k] == kche_pkg::MODE_LONG_HOLD) hold_len[k] = press_time[k];
        press_time[k] = '0;
      end else begin
        press_time[k] = bump(press_time[k]);
      end
      gap_time[k] = (mode[k] == kche_pkg::MODE_MULTI_CLICK) ? bump(gap_time[k]) : 16'd0;

      case (mode[k])
        kche_pkg::MODE_RELEASED: begin
          click_cnt[k] = '0;
          if (p) mode[k] = kche_pkg::MODE_PRE_PRESS;
        end
        kche_pkg::MODE_PRE_PRESS: begin
          if (!p) begin
            mode[k] = kche_pkg::MODE_RELEASED;
          end else if (press_time[k] > cfg.click_threshold) begin
            mode[k] = kche_pkg::MODE_PRE_LONG;
            push_event(k, kche_pkg::EV_PRESS, 8'd0, 16'd0);
          end
        end
        kche_pkg::MODE_PRE_LONG: begin
          if (!p) begin
            mode[k] = kche_pkg::MODE_MULTI_CLICK;
            if (click_cnt[k] != 8'hFF) click_cnt[k]++;
          end else if (press_time[k] > cfg.hold_threshold) begin
            mode[k] = kche_pkg::MODE_LONG_HOLD;
            repeat_left[k] = cfg.repeat_period;
            push_event(k, kche_pkg::EV_FIRST_LONG, 8'd0, 16'd0);
          end
        end
        kche_pkg::MODE_LONG_HOLD: begin
          // repeat countdown stops at zero, then reloads with an event
          if (repeat_left[k] != 0) begin
            if (repeat_left[k] > cfg.poll_period)
              repeat_left[k] = repeat_left[k] - cfg.poll_period;
            else
              repeat_left[k] = '0;
          end else begin
            repeat_left[k] = cfg.repeat_period;
            push_event(k, kche_pkg::EV_HOLD_REPEAT, 8'd0, 16'd0);
          end
          if (!p) begin
            push_event(k, kche_pkg::EV_LONG_END, 8'd0, hold_len[k]);
            push_event(k, kche_pkg::EV_RELEASE, 8'd0, 16'd0);
            mode[k] = kche_pkg::MODE_RELEASED;
          end
        end
        kche_pkg::MODE_MULTI_CLICK: begin
          if (gap_time[k] > cfg.gap_threshold) begin
            push_event(k, kche_pkg::EV_MULTI_CLICK, click_cnt[k], 16'd0);
            push_event(k, kche_pkg::EV_RELEASE, 8'd0, 16'd0);
            mode[k] = kche_pkg::MODE_RELEASED;
          end else if (press_time[k] > cfg.click_threshold) begin
            mode[k] = kche_pkg::MODE_PRE_LONG;
          end
        end
        default: mode[k] = kche_pkg::MODE_RELEASED;
      endcase

      if (awaited.size() > before_cnt) awaited[awaited.size()-1].last = 1'b1;
    endfunction

    // one accepted event against the oldest one owed
    function void check_event(logic [kche_pkg::KEY_W-1:0] k, logic [2:0] c,
                              logic [7:0] cnt, logic [15:0] hold, logic lst);
      key_event_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected event key %0d code %0d", $time, k, c);
        return;
      end
      want = awaited.pop_front();
      checked++;
      if (want.key !== k) begin
        errors++;
        $display("%0t: event_key expected %0d got %0d", $time, want.key, k);
      end
      if (want.code !== c) begin
        errors++;
        $display("%0t: event_code expected %0d got %0d", $time, want.code, c);
      end
      if (want.cnt !== cnt) begin
        errors++;
        $display("%0t: click_count expected %0d got %0d", $time, want.cnt, cnt);
      end
      if (want.hold !== hold) begin
        errors++;
        $display("%0t: hold_time expected %0d got %0d", $time, want.hold, hold);
      end
      if (want.last !== lst) begin
        errors++;
        $display("%0t: last expected %0d got %0d", $time, want.last, lst);
      end
    endfunction

    // events that never showed up
    function void report_missing();
      foreach (awaited[i])
        $display("%0t: missing event key %0d code %0d", $time, awaited[i].key,
                 awaited[i].code);
      errors += awaited.size();
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [kche_pkg::KEY_W-1:0]      key_index = '0;
  logic                            pressed = 1'b0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [kche_pkg::KEY_W-1:0]      event_key;
  logic [2:0]                      event_code;
  logic [7:0]                      click_count;
  logic [15:0]                     hold_time;
  logic                            last;
  logic                            wr_en = 1'b0;
  logic [kche_pkg::CFG_IDX_W-1:0]  wr_index = '0;
  logic [kche_pkg::CFG_DATA_W-1:0] wr_data = '0;

  key_event_tracker tracker;
  int samples_sent = 0;
  int settings_used = 0;
  bit calm = 1'b0;
  bit rx_hold_req = 1'b0;

  key_click_hold_event_fsm u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .key_index   (key_index),
    .pressed     (pressed),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .event_key   (event_key),
    .event_code  (event_code),
    .click_count (click_count),
    .hold_time   (hold_time),
    .last        (last),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // one sample request, with random idle cycles ahead of it
  task automatic send_sample(input logic [kche_pkg::KEY_W-1:0] k, input logic p);
    logic took;
    while (!calm && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    key_index <= k;
    pressed   <= p;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    tracker.note_sample(k, p);
    samples_sent++;
  endtask

  // sample on one key, sometimes preceded by a stray sample on another key
  task automatic step_key(input logic [kche_pkg::KEY_W-1:0] k, input logic p);
    if ($urandom_range(99) < 12)
      send_sample(k ^ (kche_pkg::KEY_W)'($urandom_range(1, kche_pkg::NUM_KEYS - 1)),
                  1'($urandom_range(1)));
    send_sample(k, p);
  endtask

  task automatic write_reg(input logic [kche_pkg::CFG_IDX_W-1:0] idx,
                           input logic [kche_pkg::CFG_DATA_W-1:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
    tracker.set_reg(idx, data);
  endtask

  // full register set, plus junk writes to the unmapped indexes
  task automatic program_regs(input logic [15:0] poll_data, input logic [15:0] click,
                              input logic [15:0] hold, input logic [15:0] rep,
                              input logic [15:0] gap);
    write_reg(kche_pkg::REG_POLL_PERIOD, poll_data);
    write_reg(kche_pkg::REG_CLICK_THRESHOLD, click);
    write_reg(kche_pkg::REG_HOLD_THRESHOLD, hold);
    write_reg(kche_pkg::REG_REPEAT_PERIOD, rep);
    write_reg(kche_pkg::REG_GAP_THRESHOLD, gap);
    for (int i = FIRST_UNMAPPED_IDX; i < 2 ** kche_pkg::CFG_IDX_W; i++)
      write_reg((kche_pkg::CFG_IDX_W)'(i), 16'($urandom));
    wr_en <= 1'b0;
    settings_used++;
  endtask

  // stop sending and wait for every owed event or the drain cap, then let the pipeline settle
  task automatic drain();
    int n;
    n = 0;
    in_valid <= 1'b0;
    while (tracker.awaited.size() > 0 && n < DRAIN_CAP) begin
      @(posedge clk);
      n++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // samples needed for a timer to pass a threshold, capped
  function automatic int span(logic [15:0] thr);
    int s;
    if (tracker.cfg.poll_period == 0) return 3;
    s = thr / tracker.cfg.poll_period + 2;
    return (s > MAX_RUN) ? MAX_RUN : s;
  endfunction

  // random timing, mostly in whole poll periods, sometimes at the extremes
  task automatic pick_settings();
    logic [7:0]  pp;
    logic [15:0] unit;
    logic [15:0] hold;
    case ($urandom_range(7))
      0:       pp = 8'd0;
      1:       pp = 8'hFF;
      default: pp = 8'($urandom_range(1, 6));
    endcase
    unit = (pp == 0) ? 16'd1 : {8'd0, pp};
    hold = ($urandom_range(9) == 0) ? 16'hFFFF : 16'(unit * $urandom_range(2, 10));
    program_regs({8'($urandom), pp},
                 ($urandom_range(4) == 0) ? 16'd0 : 16'(unit * $urandom_range(0, 3)),
                 hold, 16'(unit * $urandom_range(0, 5)), 16'(unit * $urandom_range(0, 6)));
  endtask

  // well-formed holds and click runs with random lengths, plus noise
  task automatic run_traffic(input int quota);
    int goal;
    int kind;
    int len;
    logic [kche_pkg::KEY_W-1:0] k;
    goal = samples_sent + quota;
    while (samples_sent < goal) begin
      k = (kche_pkg::KEY_W)'($urandom_range(kche_pkg::NUM_KEYS - 1));
      kind = $urandom_range(9);
      if (kind < 2) begin
        repeat ($urandom_range(1, 4))
          send_sample((kche_pkg::KEY_W)'($urandom_range(kche_pkg::NUM_KEYS - 1)),
                      1'($urandom_range(1)));
      end else if (kind < 6) begin
        len = $urandom_range(1, span(tracker.cfg.hold_threshold)
                                + 2 * span(tracker.cfg.repeat_period));
        repeat (len) step_key(k, 1'b1);
        repeat ($urandom_range(1, 2)) step_key(k, 1'b0);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          repeat ($urandom_range(1, span(tracker.cfg.click_threshold) + 1)) step_key(k, 1'b1);
          repeat ($urandom_range(1, span(tracker.cfg.gap_threshold))) step_key(k, 1'b0);
        end
        repeat ($urandom_range(1, span(tracker.cfg.gap_threshold) + 2)) step_key(k, 1'b0);
      end
    end
  endtask

  // event receiver: random stalls, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (RX_HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 10);
      end
    end
  end

  // event monitor: sample mid-cycle, check once the edge accepts it
  initial begin
    logic                       got;
    logic [kche_pkg::KEY_W-1:0] k;
    logic [2:0]                 c;
    logic [7:0]                 cnt;
    logic [15:0]                hold;
    logic                       lst;
    forever begin
      @(negedge clk);
      got  = !rst && out_valid && !out_stall;
      k    = event_key;
      c    = event_code;
      cnt  = click_count;
      hold = hold_time;
      lst  = last;
      @(posedge clk);
      if (got) tracker.check_event(k, c, cnt, hold, lst);
    end
  end

  // watchdog
  initial begin
    #(WATCHDOG_CYCLES * CLK_PERIOD);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int phase;
    int random_base;
    tracker = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // a few samples at the reset settings
    repeat (8)
      send_sample((kche_pkg::KEY_W)'($urandom_range(kche_pkg::NUM_KEYS - 1)),
                  1'($urandom_range(1)));
    drain();

    // long hold with repeat and underflowing countdown on the top key,
    // double click on key zero, interleaved
    program_regs(16'd4, 16'd3, 16'd12, 16'd6, 16'd6);
    send_sample(4'd15, 1'b1); send_sample(4'd0, 1'b1);
    send_sample(4'd15, 1'b1); send_sample(4'd0, 1'b1);
    send_sample(4'd15, 1'b1); send_sample(4'd0, 1'b0);
    send_sample(4'd15, 1'b1); send_sample(4'd0, 1'b1);
    send_sample(4'd15, 1'b1); send_sample(4'd0, 1'b0);
    send_sample(4'd15, 1'b1); send_sample(4'd0, 1'b0);
    send_sample(4'd15, 1'b1); send_sample(4'd0, 1'b0);
    send_sample(4'd15, 1'b0);
    drain();

    // zero poll period (upper data byte dropped) and zero thresholds: timers frozen
    program_regs(16'hFF00, 16'd0, 16'd0, 16'd0, 16'd0);
    send_sample(4'd7, 1'b1); send_sample(4'd7, 1'b1); send_sample(4'd7, 1'b0);
    drain();

    // zero thresholds with unit period: repeat every sample, three events on release
    program_regs(16'd1, 16'd0, 16'd0, 16'd0, 16'd0);
    repeat (4) send_sample(4'd8, 1'b1);
    send_sample(4'd8, 1'b0);
    send_sample(4'd9, 1'b1); send_sample(4'd9, 1'b1);
    send_sample(4'd9, 1'b0); send_sample(4'd9, 1'b0);
    drain();

    // random phases: first one without idling, second with a receiver hold-off
    random_base = samples_sent;
    phase = 0;
    while (phase < 2 || samples_sent - random_base < RANDOM_QUOTA) begin
      if (phase == 1) begin
        program_regs(16'd1, 16'd0, 16'd2, 16'd0, 16'd3);
        rx_hold_req = 1'b1;
        run_traffic(60);
      end else begin
        calm = (phase == 0);
        pick_settings();
        run_traffic($urandom_range(30, 60));
      end
      drain();
      calm = 1'b0;
      phase++;
    end

    tracker.report_missing();
    $display("run covered %0d sample requests and %0d events under %0d register settings,",
             samples_sent, tracker.checked, settings_used);
    $display("including zero period, zero thresholds, unmapped writes and hold-off backpressure");
    if (tracker.errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
